### rtl/tlpt_pkg.sv
`default_nettype none
package tlpt_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 21;

  localparam logic [1:0] K_MAP   = 2'd0;
  localparam logic [1:0] K_XLATE = 2'd1;
  localparam logic [1:0] K_FIND  = 2'd2;
  localparam logic [1:0] K_NONE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNMAPPED  = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;
  localparam logic [1:0] ST_NO_RANGE  = 2'd3;

  // directory scan covers entries 1 .. 1022
  localparam logic [IDX_W-1:0] SCAN_FIRST = 10'd1;
  localparam logic [IDX_W-1:0] SCAN_LAST  = 10'd1022;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic              write_enable;
    logic              present_flag;
    logic [CNT_W-1:0]  page_count;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [1:0]        status;
  } result_t;

endpackage
`default_nettype wire

### rtl/two_level_page_table_engine.sv
`default_nettype none
// Map: S_MAP writes the entry unless the pool is full, and raises done; an unused kind gets done from S_IDLE.
// A translate goes through S_TR_DIR, which answers a directory miss, else S_TR_PG answers.
// A find makes one directory read per entry and reads every page entry of each present table,
// then scans the directory again as a fallback; its pace is bound by the single read port.
// Throughput is one request at a time; done pulses one cycle, the receiver cannot stall.
// Synchronous reset starts a clearing pass (busy high) that zeroes the directory and page pool.
module two_level_page_table_engine
  import tlpt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire request_t req,
  output logic          done,
  output result_t       resp
);

  localparam int unsigned DIR_DEPTH = 1 << IDX_W;
  localparam int unsigned PG_DEPTH  = TABLE_SLOTS * DIR_DEPTH;
  localparam int unsigned PAW       = $clog2(PG_DEPTH);
  localparam int unsigned DW        = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CLEAR  = 8'b0000_0010,
    S_MAP    = 8'b0000_0100,
    S_TR_DIR = 8'b0000_1000,
    S_TR_PG  = 8'b0001_0000,
    S_F_DIR  = 8'b0010_0000,
    S_F_PG   = 8'b0100_0000,
    S_F_DS   = 8'b1000_0000
  } state_t;

  logic [DW-1:0] dir_mem [DIR_DEPTH];
  logic [31:0]   pg_mem  [PG_DEPTH];

  state_t            state;
  logic [PAW-1:0]    ccnt;
  logic [31:0]       va;
  logic [31:0]       pa;
  logic              we;
  logic              pr;
  logic [CNT_W-1:0]  cnt;
  logic [11:0]       need;
  logic [DW-1:0]     next_slot;
  logic [IDX_W-1:0]  d;
  logic [IDX_W:0]    pi;
  logic              pvalid;
  logic [IDX_W-1:0]  pp;
  logic [DW-1:0]     slot;
  logic [CNT_W-1:0]  run;
  logic [DW-1:0]     dir_rdata;
  logic [31:0]       pg_rdata;

  logic              accept;
  logic [IDX_W-1:0]  dir_ra;
  logic              dir_we;
  logic [IDX_W-1:0]  dir_wa;
  logic [DW-1:0]     dir_wd;
  logic [PAW-1:0]    pg_ra;
  logic              pg_we;
  logic [PAW-1:0]    pg_wa;
  logic [31:0]       pg_wd;
  logic [DW+9:0]     rd_cat;
  logic [DW+9:0]     wr_cat;
  logic [DW-1:0]     rd_slot;
  logic [DW-1:0]     map_slot;
  logic              map_new;
  logic [CNT_W-1:0]  run_inc;
  logic [19:0]       find_pg;
  logic [IDX_W-1:0]  find_dir;
  logic [CNT_W-1:0]  cnt_in;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign run_inc = run + CNT_W'(1);
  assign find_pg = {d, pp} + 20'd1 - cnt[19:0];
  assign find_dir = pp + IDX_W'(1) - need[IDX_W-1:0];
  assign cnt_in  = (req.page_count == '0) ? CNT_W'(1) : req.page_count;

  // directory read address
  always_comb begin
    case (state)
      S_IDLE:  dir_ra = (req.kind == K_FIND) ? SCAN_FIRST : req.virt_addr[31:22];
      S_F_DIR: dir_ra = d + IDX_W'(1);
      S_F_PG:  dir_ra = d + IDX_W'(1);
      S_F_DS:  dir_ra = d;
      default: dir_ra = '0;
    endcase
  end

  // page read address: slot value k names pool slot k-1
  assign rd_slot = (state == S_TR_DIR) ? dir_rdata - DW'(1) : slot - DW'(1);
  assign rd_cat  = (state == S_TR_DIR) ? {rd_slot, va[21:12]} : {rd_slot, pi[IDX_W-1:0]};
  assign pg_ra   = rd_cat[PAW-1:0];

  assign map_new  = (dir_rdata == '0);
  assign map_slot = map_new ? next_slot : dir_rdata - DW'(1);
  assign wr_cat   = {map_slot, va[21:12]};

  always_comb begin
    dir_we = 1'b0;
    dir_wa = va[31:22];
    dir_wd = next_slot + DW'(1);
    pg_we  = 1'b0;
    pg_wa  = wr_cat[PAW-1:0];
    pg_wd  = {pa[31:12], 8'h0, 2'b11, we, pr};
    case (state)
      S_CLEAR: begin
        dir_we = 1'b1;
        dir_wa = ccnt[IDX_W-1:0];
        dir_wd = '0;
        pg_we  = 1'b1;
        pg_wa  = ccnt;
        pg_wd  = '0;
      end
      S_MAP: begin
        if (!map_new || next_slot < DW'(TABLE_SLOTS)) begin
          pg_we  = 1'b1;
          dir_we = map_new;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    dir_rdata <= dir_mem[dir_ra];
    if (pg_we) pg_mem[pg_wa] <= pg_wd;
    pg_rdata <= pg_mem[pg_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ccnt      <= '0;
      next_slot <= '0;
      done      <= 1'b0;
      pvalid    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          ccnt <= ccnt + PAW'(1);
          if (ccnt == PAW'(PG_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            va   <= req.virt_addr;
            pa   <= req.phys_addr;
            we   <= req.write_enable;
            pr   <= req.present_flag;
            cnt  <= cnt_in;
            need <= 12'((22'(cnt_in) + 22'd1023) >> 10);
            d    <= SCAN_FIRST;
            run  <= '0;
            case (req.kind)
              K_MAP:   state <= S_MAP;
              K_XLATE: state <= S_TR_DIR;
              K_FIND:  state <= S_F_DIR;
              default: begin
                done <= 1'b1;
                resp <= '{result_addr: '0, status: ST_OK};
              end
            endcase
          end
        end
        S_MAP: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (map_new && next_slot >= DW'(TABLE_SLOTS)) begin
            resp <= '{result_addr: '0, status: ST_POOL_FULL};
          end else begin
            resp <= '{result_addr: '0, status: ST_OK};
            if (map_new) next_slot <= next_slot + DW'(1);
          end
        end
        S_TR_DIR: begin
          if (dir_rdata == '0) begin
            done  <= 1'b1;
            resp  <= '{result_addr: '0, status: ST_UNMAPPED};
            state <= S_IDLE;
          end else begin
            state <= S_TR_PG;
          end
        end
        S_TR_PG: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (pg_rdata[0]) resp <= '{result_addr: {pg_rdata[31:12], va[11:0]}, status: ST_OK};
          else resp <= '{result_addr: '0, status: ST_UNMAPPED};
        end
        S_F_DIR: begin
          if (dir_rdata == '0) begin
            run <= '0;
            if (d == SCAN_LAST) begin
              d     <= SCAN_FIRST;
              state <= S_F_DS;
            end else begin
              d <= d + IDX_W'(1);
            end
          end else begin
            slot   <= dir_rdata;
            pi     <= '0;
            pvalid <= 1'b0;
            state  <= S_F_PG;
          end
        end
        S_F_PG: begin
          if (!pi[IDX_W]) begin
            pi     <= pi + (IDX_W+1)'(1);
            pvalid <= 1'b1;
            pp     <= pi[IDX_W-1:0];
          end else begin
            pvalid <= 1'b0;
          end
          if (pvalid) begin
            if (!pg_rdata[0] && run_inc >= cnt) begin
              done   <= 1'b1;
              resp   <= '{result_addr: {find_pg, 12'h0}, status: ST_OK};
              pvalid <= 1'b0;
              state  <= S_IDLE;
            end else if (pp == '1) begin
              pvalid <= 1'b0;
              if (d == SCAN_LAST) begin
                d     <= SCAN_FIRST;
                run   <= '0;
                state <= S_F_DS;
              end else begin
                d     <= d + IDX_W'(1);
                run   <= pg_rdata[0] ? '0 : run_inc;
                state <= S_F_DIR;
              end
            end else begin
              run <= pg_rdata[0] ? '0 : run_inc;
            end
          end
        end
        S_F_DS: begin
          // issue one directory read a cycle, check the one issued before
          if (d != '1) begin
            d      <= d + IDX_W'(1);
            pvalid <= 1'b1;
            pp     <= d;
          end else begin
            pvalid <= 1'b0;
          end
          if (pvalid) begin
            if (dir_rdata == '0 && 12'(run_inc) >= need) begin
              done   <= 1'b1;
              resp   <= '{result_addr: {find_dir, 22'h0}, status: ST_OK};
              pvalid <= 1'b0;
              state  <= S_IDLE;
            end else if (pp == SCAN_LAST) begin
              done   <= 1'b1;
              resp   <= '{result_addr: '0, status: ST_NO_RANGE};
              pvalid <= 1'b0;
              state  <= S_IDLE;
            end else begin
              run <= (dir_rdata == '0) ? run_inc : '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_err_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (done && resp.status != ST_OK) |-> resp.result_addr == '0)
    else $error("non-ok result carries an address");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    next_slot <= DW'(TABLE_SLOTS))
    else $error("pool slot counter overran");

  a_no_done_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !done)
    else $error("result during clearing pass");

  a_map_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && req.kind == K_MAP) |=> busy && !done)
    else $error("map request not held for its directory read");

endmodule
`default_nettype wire

### verif/two_level_page_table_engine_test.sv
`timescale 1ns / 1ps

module two_level_page_table_engine_test;
  import tlpt_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned N_RANDOM = 880;

  class walk_scoreboard;
    logic [4:0]  dir_tab [1024];
    logic [31:0] pte_tab [SLOTS*1024];
    int unsigned slot_next;
    result_t     want_q [$];
    int          errors;

    function new();
      foreach (dir_tab[i]) dir_tab[i] = '0;
      foreach (pte_tab[i]) pte_tab[i] = '0;
      slot_next = 0;
      errors = 0;
    endfunction

    function bit has_table(int unsigned d, output int unsigned slot);
      int unsigned v;
      v = 32'(dir_tab[d]);
      slot = 0;
      if (v == 0 || v > SLOTS) return 0;
      slot = v - 1;
      return 1;
    endfunction

    function void find_range(int unsigned count, output result_t r);
      int unsigned slot, run, need;
      r = '{result_addr: '0, status: ST_NO_RANGE};
      if (count == 0) count = 1;
      run = 0;
      for (int unsigned d = 1; d < 1023; d++) begin
        if (!has_table(d, slot)) begin
          run = 0;
          continue;
        end
        for (int unsigned p = 0; p < 1024; p++) begin
          if (pte_tab[slot*1024 + p][0] == 1'b0) begin
            run++;
            if (run >= count) begin
              r.result_addr = 32'((d*1024 + p + 1 - count) << 12);
              r.status = ST_OK;
              return;
            end
          end else begin
            run = 0;
          end
        end
      end
      need = (count + 1023) / 1024;
      run = 0;
      for (int unsigned d = 1; d < 1023; d++) begin
        if (!has_table(d, slot)) begin
          run++;
          if (run >= need) begin
            r.result_addr = 32'((d + 1 - need) << 22);
            r.status = ST_OK;
            return;
          end
        end else begin
          run = 0;
        end
      end
    endfunction

    // predict the response of an accepted request and queue it
    function void note_request(request_t q);
      result_t     r;
      int unsigned d, p, slot;
      logic [31:0] e;
      r = '{result_addr: '0, status: ST_OK};
      d = 32'(q.virt_addr[31:22]);
      p = 32'(q.virt_addr[21:12]);
      case (q.kind)
        K_MAP: begin
          if (!has_table(d, slot)) begin
            if (slot_next >= SLOTS) begin
              r.status = ST_POOL_FULL;
            end else begin
              slot = slot_next;
              slot_next++;
              dir_tab[d] = 5'(slot + 1);
            end
          end
          if (r.status == ST_OK)
            pte_tab[slot*1024 + p] = (q.phys_addr & 32'hFFFFF000) | 32'd12 |
                                     {30'd0, q.write_enable, q.present_flag};
        end
        K_XLATE: begin
          if (!has_table(d, slot)) begin
            r.status = ST_UNMAPPED;
          end else begin
            e = pte_tab[slot*1024 + p];
            if (!e[0]) r.status = ST_UNMAPPED;
            else r.result_addr = {e[31:12], q.virt_addr[11:0]};
          end
        end
        K_FIND: find_range(32'(q.page_count), r);
        default: ;
      endcase
      want_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t w;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected response addr=%h status=%0d", $time,
                 got.result_addr, got.status);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (got.result_addr !== w.result_addr) begin
        $display("%0t: result_addr expected %h actual %h", $time, w.result_addr,
                 got.result_addr);
        errors++;
      end
      if (got.status !== w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, w.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t req;
  logic     done;
  result_t  resp;

  walk_scoreboard sb;
  bit             idle_on;

  two_level_page_table_engine #(.TABLE_SLOTS(SLOTS)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .resp (resp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(resp);
  end

  task automatic send_request(request_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  function automatic request_t mk(logic [1:0] k, logic [31:0] va, logic [31:0] pa,
                                  logic we, logic pr, logic [20:0] cnt);
    request_t r;
    r.kind = k;
    r.virt_addr = va;
    r.phys_addr = pa;
    r.write_enable = we;
    r.present_flag = pr;
    r.page_count = cnt;
    return r;
  endfunction

  // virtual addresses mostly fall in a few directory entries and pages so walks hit
  function automatic logic [31:0] pick_va();
    logic [9:0] d, p;
    case ($urandom_range(0, 9))
      0: d = 10'd0;
      1: d = 10'd1023;
      2: d = 10'd1022;
      3: d = 10'd1;
      9: d = 10'($urandom);
      default: d = 10'($urandom_range(0, 23));
    endcase
    p = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
    return {d, p, 12'($urandom)};
  endfunction

  function automatic logic [20:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 21'($urandom);
      1: return 21'($urandom_range(1000, 3000));
      2: return 21'd0;
      default: return 21'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic request_t random_request();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45)
      return mk(K_MAP, pick_va(), $urandom, 1'($urandom), ($urandom_range(0, 4) != 0),
                21'($urandom));
    if (sel < 92)
      return mk(K_XLATE, pick_va(), $urandom, 1'($urandom), 1'($urandom),
                21'($urandom));
    if (sel < 98)
      return mk(K_FIND, $urandom, $urandom, 1'($urandom), 1'($urandom), pick_count());
    return mk(K_NONE, $urandom, $urandom, 1'($urandom), 1'($urandom), 21'($urandom));
  endfunction

  initial begin
    sb = new();
    idle_on = 1'b1;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_request(mk(K_XLATE, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 21'd0));
    send_request(mk(K_FIND, 32'h0, 32'h0, 1'b0, 1'b0, 21'd0));
    send_request(mk(K_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 21'h1FFFFF));
    send_request(mk(K_XLATE, 32'h0000_0FFF, 32'h0, 1'b0, 1'b0, 21'd0));
    send_request(mk(K_MAP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 21'd0));
    send_request(mk(K_XLATE, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 21'd0));
    send_request(mk(K_MAP, 32'h0040_1000, 32'h1234_5000, 1'b1, 1'b0, 21'd0));
    send_request(mk(K_XLATE, 32'h0040_1234, 32'h0, 1'b0, 1'b0, 21'd0));
    send_request(mk(K_XLATE, 32'h0040_2000, 32'h0, 1'b0, 1'b0, 21'd0));
    send_request(mk(K_XLATE, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 21'd0));
    send_request(mk(K_FIND, 32'h0, 32'h0, 1'b0, 1'b0, 21'd1));
    send_request(mk(K_MAP, 32'h0080_0000, 32'hABCD_E000, 1'b0, 1'b1, 21'd0));
    // run too long for the free pages of the tables at directory 1 and 2; the fallback scan answers
    send_request(mk(K_FIND, 32'h0, 32'h0, 1'b0, 1'b0, 21'd1500));
    send_request(mk(K_FIND, 32'h0, 32'h0, 1'b0, 1'b0, 21'd1024));
    send_request(mk(K_FIND, 32'h0, 32'h0, 1'b0, 1'b0, 21'd1048576));
    send_request(mk(K_FIND, 32'h0, 32'h0, 1'b0, 1'b0, 21'h1FFFFF));
    send_request(mk(K_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 21'h1FFFFF));
    send_request(mk(K_XLATE, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 21'd0));

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (sb.want_q.size() != 0) @(posedge clk);
      end
      if (i == N_RANDOM - 150) idle_on = 1'b0;
      send_request(random_request());
    end
    start <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/tlpt_pkg.sv
rtl/two_level_page_table_engine.sv
verif/two_level_page_table_engine_test.sv
